/* design/pfa_pkg.sv */
package pfa_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);

    // Fixed field widths of the item formats
    localparam int TYPE_FIELD_W = 1;
    localparam int BLK_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int MODE_W       = 2;

    // Command queue between front and back
    localparam int QPTR_W  = 1;
    localparam int Q_DEPTH = 2 ** QPTR_W;

    // Items in flight at most: queue, back engine, output register
    localparam int MAX_OUTSTANDING = Q_DEPTH + 2;
    localparam int OUTST_W         = $clog2(MAX_OUTSTANDING + 1);

    // Request types
    localparam logic [TYPE_FIELD_W-1:0] REQ_LOAD     = 1'b0;
    localparam logic [TYPE_FIELD_W-1:0] REQ_ALLOCATE = 1'b1;

    // Search policies
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
    localparam logic [MODE_W-1:0] FIT_NONE  = 2'd3;

    typedef struct packed {
        logic [TYPE_FIELD_W-1:0] req_type;
        logic [BLK_FIELD_W-1:0]  block_index;
        logic [SIZE_FIELD_W-1:0] size_value;
    } in_item_t;

    typedef struct packed {
        logic                    placed;
        logic [BLK_FIELD_W-1:0]  placed_block;
        logic [SIZE_FIELD_W-1:0] remaining_after;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic                   is_load;
        logic                   in_range;
        logic [BLK_FIELD_W-1:0] block_index;
        logic [SIZE_WIDTH-1:0]  size;
    } cmd_t;

endpackage

/* design/partition_fit_allocator_top.sv */
// Channel   | Ports                      | Direction | Carries
// ----------+----------------------------+-----------+------------------------------------
// input     | s_valid, s_ready, s_data   | in        | load or allocate item
// result    | m_valid, m_ready, m_data   | out       | placement result, one per item
// config    | cfg_wr_en, cfg_wr_data     | in        | fit_mode, written with no wait
//
// Steps: a load item passes the queue, the table write and the output register.
// An allocate item passes the queue, then the back engine walks the table one
// partition per cycle, then a write-back state and the output register; first fit
// stops at the first partition that fits. The single table read port sets this pace.
// Reset: aresetn low for one edge clears the table, the marks, fit_mode and the queue.
// Stalls: the input side keeps accepting until the two-entry queue fills; a
// held output item stalls only the back engine.
module partition_fit_allocator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pfa_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pfa_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pfa_pkg::out_item_t          m_data
);

    logic          cmd_valid;
    logic          cmd_pop;
    pfa_pkg::cmd_t cmd_head;

    // Front: accept, classify and queue items
    pfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_head  (cmd_head)
    );

    // Back: hold the table, run the search, register the result item
    pfa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd_head    (cmd_head),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* design/pfa_front.sv */
module pfa_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfa_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output pfa_pkg::cmd_t     cmd_head
);

    pfa_pkg::cmd_t                 q_reg [pfa_pkg::Q_DEPTH];
    logic [pfa_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pfa_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pfa_pkg::QPTR_W:0]      count_reg, count_next;
    pfa_pkg::cmd_t                 cmd_in;
    logic                          push;
    logic                          pop;

    // Classify the incoming item
    always_comb begin
        cmd_in.is_load     = (s_data.req_type == pfa_pkg::REQ_LOAD);
        cmd_in.in_range    = (32'(s_data.block_index) < 32'(pfa_pkg::NUM_BLOCKS));
        cmd_in.block_index = s_data.block_index;
        cmd_in.size        = pfa_pkg::SIZE_WIDTH'(s_data.size_value);
    end

    assign s_ready   = (count_reg != (pfa_pkg::QPTR_W+1)'(pfa_pkg::Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_head  = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* design/pfa_back.sv */
module pfa_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [pfa_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    input  pfa_pkg::cmd_t               cmd_head,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pfa_pkg::out_item_t          m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    localparam logic [pfa_pkg::IDX_W-1:0] LAST_IDX = pfa_pkg::IDX_W'(pfa_pkg::NUM_BLOCKS - 1);

    state_t                             state_reg, state_next;
    logic [pfa_pkg::MODE_W-1:0]         mode_reg;
    logic [pfa_pkg::IDX_W-1:0]          scan_reg, scan_next;
    logic [pfa_pkg::IDX_W-1:0]          pick_reg, pick_next;
    logic [pfa_pkg::SIZE_WIDTH-1:0]     pick_size_reg, pick_size_next;
    logic [pfa_pkg::SIZE_WIDTH-1:0]     size_reg, size_next;
    logic                               found_reg, found_next;
    pfa_pkg::out_item_t                 res_reg, res_next;
    logic                               m_valid_reg, m_valid_next;
    pfa_pkg::out_item_t                 m_data_reg, m_data_next;

    logic [pfa_pkg::SIZE_WIDTH-1:0]     rem_reg [pfa_pkg::NUM_BLOCKS];
    logic [pfa_pkg::NUM_BLOCKS-1:0]     occ_reg;

    logic                               tbl_we;
    logic [pfa_pkg::IDX_W-1:0]          tbl_idx;
    logic [pfa_pkg::SIZE_WIDTH-1:0]     tbl_rem;
    logic                               tbl_occ;
    logic                               tbl_rem_we;

    logic [pfa_pkg::SIZE_WIDTH-1:0]     cur;
    logic                               fits;
    logic                               better;
    logic [pfa_pkg::SIZE_WIDTH-1:0]     new_rem;

    assign cur  = rem_reg[scan_reg];
    assign fits = (cur >= size_reg);

    always_comb begin
        case (mode_reg)
            pfa_pkg::FIT_BEST:  better = !found_reg || (cur < pick_size_reg);
            pfa_pkg::FIT_WORST: better = !found_reg || (cur > pick_size_reg);
            default:            better = 1'b0;
        endcase
    end

    assign new_rem = (mode_reg == pfa_pkg::FIT_BEST) ? pick_size_reg
                                                      : pick_size_reg - size_reg;

    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pick_next      = pick_reg;
        pick_size_next = pick_size_reg;
        size_next      = size_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        cmd_pop        = 1'b0;
        tbl_we         = 1'b0;
        tbl_rem_we     = 1'b0;
        tbl_idx        = pick_reg;
        tbl_rem        = new_rem;
        tbl_occ        = 1'b1;

        // Drop the output item once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    if (cmd_head.is_load) begin
                        tbl_idx    = pfa_pkg::IDX_W'(cmd_head.block_index);
                        tbl_rem    = cmd_head.size;
                        tbl_occ    = 1'b0;
                        tbl_we     = cmd_head.in_range;
                        tbl_rem_we = cmd_head.in_range;
                        res_next.placed          = 1'b0;
                        res_next.placed_block    = cmd_head.block_index;
                        res_next.remaining_after = cmd_head.in_range
                            ? pfa_pkg::SIZE_FIELD_W'(cmd_head.size) : '0;
                        state_next = ST_RESP;
                    end else begin
                        size_next  = cmd_head.size;
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (fits && mode_reg == pfa_pkg::FIT_FIRST) begin
                    found_next     = 1'b1;
                    pick_next      = scan_reg;
                    pick_size_next = cur;
                    state_next     = ST_WRITE;
                end else begin
                    if (fits && !occ_reg[scan_reg] && better) begin
                        found_next     = 1'b1;
                        pick_next      = scan_reg;
                        pick_size_next = cur;
                    end
                    if (scan_reg == LAST_IDX) begin
                        state_next = ST_WRITE;
                    end else begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            ST_WRITE: begin
                if (found_reg) begin
                    tbl_rem_we = (mode_reg != pfa_pkg::FIT_BEST);
                    tbl_we     = (mode_reg != pfa_pkg::FIT_FIRST);
                    res_next.placed          = 1'b1;
                    res_next.placed_block    = pfa_pkg::BLK_FIELD_W'(pick_reg);
                    res_next.remaining_after = pfa_pkg::SIZE_FIELD_W'(new_rem);
                end else begin
                    res_next = '0;
                end
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= pfa_pkg::FIT_FIRST;
            m_valid_reg   <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
            pick_reg      <= '0;
            pick_size_reg <= '0;
            size_reg      <= '0;
            res_reg       <= '0;
            m_data_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            found_reg     <= found_next;
            scan_reg      <= scan_next;
            pick_reg      <= pick_next;
            pick_size_reg <= pick_size_next;
            size_reg      <= size_next;
            res_reg       <= res_next;
            m_data_reg    <= m_data_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Partition table: remaining sizes and occupied marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pfa_pkg::NUM_BLOCKS; i++) begin
                rem_reg[i] <= '0;
            end
            occ_reg <= '0;
        end else begin
            if (tbl_rem_we) begin
                rem_reg[tbl_idx] <= tbl_rem;
            end
            if (tbl_we) begin
                occ_reg[tbl_idx] <= tbl_occ;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/pfa_checker.sv */
module pfa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input pfa_pkg::out_item_t  m_data
);

    logic [pfa_pkg::OUTST_W-1:0] outst_reg, outst_next;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        outst_next = outst_reg;
        if (in_acc && !out_acc) begin
            outst_next = outst_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outst_reg <= '0;
        end else begin
            outst_reg <= outst_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outst_reg != '0)
        else $error("result item without an outstanding input item");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        outst_reg == pfa_pkg::OUTST_W'(pfa_pkg::MAX_OUTSTANDING) |-> !s_ready)
        else $error("input accepted beyond internal capacity");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
